>>> hdl/mqsb_pkg.sv
// shared types and constants of the multi-queue shared buffer
package mqsb_pkg;

    localparam int SLOTS    = 16;
    localparam int QUEUES   = 4;
    localparam int DATA_W   = 32;
    localparam int QSEL_W   = 2;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = $clog2(SLOTS);
    localparam int PTR_W    = $clog2(SLOTS + 1);

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [PTR_W-1:0]    ptr_t;
    typedef logic [DATA_W-1:0]   data_t;
    typedef logic [QSEL_W-1:0]   qsel_t;
    typedef logic [STATUS_W-1:0] status_t;

    // null link is the pointer one past the last slot
    localparam ptr_t NULL_PTR = PTR_W'(SLOTS);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_OVERFLOW = 2'd1;
    localparam status_t STATUS_EMPTY    = 2'd2;

    // write port of the link memory
    typedef struct packed {
        logic en;
        idx_t addr;
        ptr_t data;
    } link_wr_t;

endpackage

>>> hdl/mqsb_link_mem.sv
// next-pointer memory with per-slot written bits standing in for the reset chain
module mqsb_link_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  mqsb_pkg::idx_t     rd_addr,
    output mqsb_pkg::ptr_t     rd_data,
    input  mqsb_pkg::link_wr_t wr
);

    mqsb_pkg::ptr_t              mem [mqsb_pkg::SLOTS];
    logic [mqsb_pkg::SLOTS-1:0]  written_reg;
    mqsb_pkg::ptr_t              raw_reg;
    mqsb_pkg::idx_t              addr_reg;
    logic                        hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            raw_reg  <= mem[rd_addr];
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            hit_reg     <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= written_reg[rd_addr];
            end
        end
    end

    // an unwritten slot links to the one after it, the last to null
    assign rd_data = hit_reg ? raw_reg
                             : mqsb_pkg::PTR_W'(addr_reg) + mqsb_pkg::PTR_W'(1);

endmodule

>>> hdl/mqsb_value_ram.sv
// slot value store, one write and one registered read port
module mqsb_value_ram (
    input  logic            clk,
    input  logic            wr_en,
    input  mqsb_pkg::idx_t  wr_addr,
    input  mqsb_pkg::data_t wr_data,
    input  logic            rd_en,
    input  mqsb_pkg::idx_t  rd_addr,
    output mqsb_pkg::data_t rd_data
);

    mqsb_pkg::data_t mem [mqsb_pkg::SLOTS];
    mqsb_pkg::data_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/multi_queue_shared_buffer_core.sv
// top level: several fifo queues linked through one shared slot store
//
// input channel s_axis: one command per transfer. tuser carries the command
// (bit 0: 0 enqueue, 1 dequeue) and the queue number (bits 2:1); tdata carries
// the value to enqueue, ignored on dequeue.
// output channel m_axis: one result per command. tdata is the dequeued value
// (all ones on an empty queue, zero for enqueue), tuser the status code
// (ok, overflow, empty).
// each command runs through the idle and exec states: on accept, idle reads the link and value
// memories at the free-list head or the queue head, and exec then writes
// the link back and updates head, tail and free pointers. one command is in
// flight at a time: no new command is taken until the current one leaves exec.
// the result sits in an output register; a new command is taken while it
// waits. if the receiver stalls with a result still pending, the block holds
// the finished command until the register frees, keeping ready low meanwhile.
// reset empties all queues and chains every slot into the free list at once
// through per-slot written bits; no clearing pass is needed.
module multi_queue_shared_buffer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // value_in
    input  logic [2:0]  s_axis_tuser,   // cmd, queue_index
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // value_out
    output logic [1:0]  m_axis_tuser    // status
);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t              state_reg;
    logic                cmd_reg;
    mqsb_pkg::qsel_t     q_reg;
    mqsb_pkg::data_t     val_reg;
    mqsb_pkg::ptr_t      slot_reg;
    logic                fail_reg;
    logic                head_null_reg;
    logic                head_is_tail_reg;
    mqsb_pkg::ptr_t      tail_reg;
    mqsb_pkg::ptr_t      free_head_reg;
    mqsb_pkg::ptr_t      heads_reg [mqsb_pkg::QUEUES];
    mqsb_pkg::ptr_t      tails_reg [mqsb_pkg::QUEUES];
    logic                out_valid_reg;
    mqsb_pkg::data_t     out_data_reg;
    mqsb_pkg::status_t   out_status_reg;

    logic                accept;
    logic                in_cmd;
    mqsb_pkg::qsel_t     in_q;
    logic                q_ok;
    mqsb_pkg::ptr_t      sel_ptr;
    logic                in_fail;
    logic                exec_done;
    mqsb_pkg::ptr_t      link_rdata;
    mqsb_pkg::data_t     val_rdata;
    mqsb_pkg::link_wr_t  link_wr;
    logic                val_we;

    // input side: a new command only in idle
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_cmd        = s_axis_tuser[0];
    assign in_q          = s_axis_tuser[2:1];
    assign q_ok          = (32'(in_q) < 32'(mqsb_pkg::QUEUES));

    // enqueue works on the free-list head, dequeue on the queue head
    assign sel_ptr = (in_cmd == mqsb_pkg::CMD_ENQ) ? free_head_reg : heads_reg[in_q];
    assign in_fail = !q_ok || (sel_ptr == mqsb_pkg::NULL_PTR);

    // finish once the output register is free or being drained
    assign exec_done = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);

    // link write: enqueue appends behind the live tail, dequeue pushes the
    // freed slot in front of the free list; the new tail keeps a stale link,
    // dequeue detects the last entry by head equal to tail instead
    always_comb
    begin
        link_wr.en   = 1'b0;
        link_wr.addr = slot_reg[mqsb_pkg::IDX_W-1:0];
        link_wr.data = free_head_reg;
        if (exec_done && !fail_reg)
        begin
            if (cmd_reg == mqsb_pkg::CMD_ENQ)
            begin
                link_wr.en   = !head_null_reg;
                link_wr.addr = tail_reg[mqsb_pkg::IDX_W-1:0];
                link_wr.data = slot_reg;
            end
            else
            begin
                link_wr.en = 1'b1;
            end
        end
    end

    assign val_we = exec_done && !fail_reg && (cmd_reg == mqsb_pkg::CMD_ENQ);

    mqsb_link_mem u_link_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (sel_ptr[mqsb_pkg::IDX_W-1:0]),
        .rd_data (link_rdata),
        .wr      (link_wr)
    );

    mqsb_value_ram u_value_ram (
        .clk     (clk),
        .wr_en   (val_we),
        .wr_addr (slot_reg[mqsb_pkg::IDX_W-1:0]),
        .wr_data (val_reg),
        .rd_en   (accept),
        .rd_addr (sel_ptr[mqsb_pkg::IDX_W-1:0]),
        .rd_data (val_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cmd_reg          <= mqsb_pkg::CMD_ENQ;
            q_reg            <= '0;
            val_reg          <= '0;
            slot_reg         <= mqsb_pkg::NULL_PTR;
            fail_reg         <= 1'b0;
            head_null_reg    <= 1'b1;
            head_is_tail_reg <= 1'b0;
            tail_reg         <= mqsb_pkg::NULL_PTR;
            free_head_reg    <= '0;
            for (int i = 0; i < mqsb_pkg::QUEUES; i++)
            begin
                heads_reg[i] <= mqsb_pkg::NULL_PTR;
                tails_reg[i] <= mqsb_pkg::NULL_PTR;
            end
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            out_status_reg   <= mqsb_pkg::STATUS_OK;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg          <= in_cmd;
                        q_reg            <= in_q;
                        val_reg          <= s_axis_tdata;
                        slot_reg         <= sel_ptr;
                        fail_reg         <= in_fail;
                        head_null_reg    <= (heads_reg[in_q] == mqsb_pkg::NULL_PTR);
                        head_is_tail_reg <= (heads_reg[in_q] == tails_reg[in_q]);
                        tail_reg         <= tails_reg[in_q];
                        state_reg        <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    if (exec_done)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (fail_reg)
                        begin
                            if (cmd_reg == mqsb_pkg::CMD_ENQ)
                            begin
                                out_data_reg   <= '0;
                                out_status_reg <= mqsb_pkg::STATUS_OVERFLOW;
                            end
                            else
                            begin
                                out_data_reg   <= '1;
                                out_status_reg <= mqsb_pkg::STATUS_EMPTY;
                            end
                        end
                        else if (cmd_reg == mqsb_pkg::CMD_ENQ)
                        begin
                            free_head_reg    <= link_rdata;
                            tails_reg[q_reg] <= slot_reg;
                            if (head_null_reg)
                            begin
                                heads_reg[q_reg] <= slot_reg;
                            end
                            out_data_reg   <= '0;
                            out_status_reg <= mqsb_pkg::STATUS_OK;
                        end
                        else
                        begin
                            heads_reg[q_reg] <= head_is_tail_reg ? mqsb_pkg::NULL_PTR
                                                                 : link_rdata;
                            free_head_reg    <= slot_reg;
                            out_data_reg     <= val_rdata;
                            out_status_reg   <= mqsb_pkg::STATUS_OK;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // one command in flight: ready drops right after a transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("command accepted while another is in flight");

    // an empty result always carries all ones
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == mqsb_pkg::STATUS_EMPTY))
            |-> (m_axis_tdata == '1))
        else $error("empty status without all-ones value");

    // a successful command always works on a real slot
    a_real_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_done && !fail_reg) |-> (slot_reg != mqsb_pkg::NULL_PTR))
        else $error("successful command on the null slot");

    // a completed command leaves a pending result
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        exec_done |=> m_axis_tvalid)
        else $error("completed command produced no result");

endmodule

>>> tb/testbench.sv
// self-checking testbench for the multi-queue shared buffer core
module testbench;

    import mqsb_pkg::*;

    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_LIMIT   = 4000;   // cycles with no transfer on either side
    localparam int DRAIN_CYCLES = 20;

    // one result as it leaves the block
    typedef struct packed {
        data_t   value;
        status_t status;
    } result_t;

    // one row of the directed table; fixed rows carry a typed-in result
    typedef struct packed {
        logic    cmd;
        qsel_t   qsel;
        data_t   value;
        logic    fixed;
        result_t want;
    } dir_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // value_in
    logic [2:0]  s_axis_tuser  = '0;   // cmd, queue_index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // value_out
    logic [1:0]  m_axis_tuser;         // status

    // shadow copy of the queue structure
    data_t   slot_val  [SLOTS];
    ptr_t    slot_next [SLOTS];
    ptr_t    head_ptr  [QUEUES];
    ptr_t    tail_ptr  [QUEUES];
    ptr_t    free_ptr;

    result_t pending_results[$];
    int      mismatches   = 0;
    int      idle_cycles  = 0;
    int      burst_left   = 1;
    int      enq_sent     = 0;
    int      deq_sent     = 0;
    int      results_seen = 0;
    int      overflows    = 0;
    int      empties      = 0;

    always #10 clk = ~clk;

    multi_queue_shared_buffer_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic bit is_slot(ptr_t p);
        return int'(p) < SLOTS;
    endfunction

    // applies one command to the shadow queues and returns its result
    function automatic result_t apply_command(logic cmd, qsel_t qsel, data_t value);
        result_t r;
        ptr_t    slot;
        r.value  = '0;
        r.status = STATUS_OK;
        if (cmd == CMD_ENQ)
        begin
            if (int'(qsel) >= QUEUES || !is_slot(free_ptr))
            begin
                r.status = STATUS_OVERFLOW;
            end
            else
            begin
                slot     = free_ptr;
                free_ptr = slot_next[slot[IDX_W-1:0]];
                // an emptied queue keeps a stale tail, so the head decides
                if (!is_slot(head_ptr[qsel]))
                    head_ptr[qsel] = slot;
                else if (is_slot(tail_ptr[qsel]))
                    slot_next[tail_ptr[qsel][IDX_W-1:0]] = slot;
                slot_next[slot[IDX_W-1:0]] = NULL_PTR;
                tail_ptr[qsel]             = slot;
                slot_val[slot[IDX_W-1:0]]  = value;
            end
        end
        else
        begin
            if (int'(qsel) >= QUEUES || !is_slot(head_ptr[qsel]))
            begin
                r.value  = '1;
                r.status = STATUS_EMPTY;
            end
            else
            begin
                slot                       = head_ptr[qsel];
                head_ptr[qsel]             = slot_next[slot[IDX_W-1:0]];
                slot_next[slot[IDX_W-1:0]] = free_ptr;
                free_ptr                   = slot;
                r.value                    = slot_val[slot[IDX_W-1:0]];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, result_t want, result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected value %h status %0d, got value %h status %0d",
                     $time, what, want.value, want.status, got.value, got.status);
    endtask

    // offers one command and waits for its transfer; the sender runs in bursts
    task automatic send_command(logic cmd, qsel_t qsel, data_t value, logic fixed,
                                result_t want);
        result_t predicted;
        int      gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {qsel, cmd};
        s_axis_tdata  <= value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = apply_command(cmd, qsel, value);
        pending_results.push_back(fixed ? want : predicted);
        if (cmd == CMD_ENQ)
            enq_sent++;
        else
            deq_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver stall pattern, reloaded once its last bit has been used
    logic [15:0] ready_pattern = '1;
    int          pattern_pos   = 0;

    always @(posedge clk)
    begin
        m_axis_tready <= ready_pattern[pattern_pos];
        if (pattern_pos == 15)
        begin
            pattern_pos <= 0;
            case ($urandom_range(0, 7))
                0, 1:    ready_pattern <= '1;   // no stalls at all
                2:       ready_pattern <= '0;   // one long stall
                3:       ready_pattern <= 16'h5555;
                default: ready_pattern <= 16'($urandom);
            endcase
        end
        else
        begin
            pattern_pos <= pattern_pos + 1;
        end
    end

    // result checker: every result against the oldest expectation
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.value  = m_axis_tdata;
            got.status = m_axis_tuser;
            results_seen++;
            if (got.status == STATUS_OVERFLOW)
                overflows++;
            if (got.status == STATUS_EMPTY)
                empties++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with no command outstanding", '0, got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.value !== want.value)
                    report_mismatch("value_out mismatch", want, got);
                if (got.status !== want.status)
                    report_mismatch("status mismatch", want, got);
            end
        end
    end

    // watchdog: counts cycles in which no transfer happens on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        dir_row_t dir_rows [25];
        result_t  none;
        result_t  ok_enq;
        result_t  empty_deq;
        result_t  full_enq;
        int       enq_pct;
        int       mode_left;
        int       favored;
        bit       focus;
        logic     cmd;
        qsel_t    qsel;
        data_t    value;
        data_t    corners [4];

        corners   = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
        none      = '0;
        ok_enq    = '{value: '0, status: STATUS_OK};
        empty_deq = '{value: '1, status: STATUS_EMPTY};
        full_enq  = '{value: '0, status: STATUS_OVERFLOW};

        // shadow state after reset: all queues empty, every slot on the free list
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_val[i]  = '0;
            slot_next[i] = ptr_t'(i + 1);
        end
        for (int i = 0; i < QUEUES; i++)
        begin
            head_ptr[i] = NULL_PTR;
            tail_ptr[i] = NULL_PTR;
        end
        free_ptr = '0;

        // directed table: empty queues, extreme values, stale tail, full store
        dir_rows[0]  = '{CMD_DEQ, 2'd0, 32'h0000_0000, 1'b1, empty_deq};
        dir_rows[1]  = '{CMD_DEQ, 2'd3, 32'hffff_ffff, 1'b1, empty_deq};
        dir_rows[2]  = '{CMD_ENQ, 2'd0, 32'h8000_0000, 1'b1, ok_enq};
        dir_rows[3]  = '{CMD_ENQ, 2'd0, 32'h7fff_ffff, 1'b1, ok_enq};
        dir_rows[4]  = '{CMD_DEQ, 2'd0, 32'h1234_5678, 1'b0, none};
        dir_rows[5]  = '{CMD_DEQ, 2'd0, 32'h0000_0000, 1'b0, none};
        dir_rows[6]  = '{CMD_DEQ, 2'd0, 32'h0000_0000, 1'b1, empty_deq};
        // queue 0 is empty again with its tail left behind
        dir_rows[7]  = '{CMD_ENQ, 2'd0, 32'hffff_ffff, 1'b1, ok_enq};
        dir_rows[8]  = '{CMD_ENQ, 2'd3, 32'h0000_0000, 1'b1, ok_enq};
        // fill the remaining fourteen slots across all queues
        for (int i = 9; i < 23; i++)
            dir_rows[i] = '{CMD_ENQ, qsel_t'(i), {8{4'(i)}}, 1'b1, ok_enq};
        dir_rows[23] = '{CMD_ENQ, 2'd1, 32'h1234_5678, 1'b1, full_enq};
        dir_rows[24] = '{CMD_DEQ, 2'd0, 32'h0000_0000, 1'b0, none};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_command(dir_rows[i].cmd, dir_rows[i].qsel, dir_rows[i].value,
                         dir_rows[i].fixed, dir_rows[i].want);

        // random part: modes lean toward enqueue or dequeue so the fill level
        // swings between empty and full, sometimes crowding one queue
        mode_left = 0;
        enq_pct   = 50;
        favored   = 0;
        focus     = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(10, 60);
                favored   = $urandom_range(0, QUEUES - 1);
                focus     = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 4))
                    0:       enq_pct = 85;
                    1:       enq_pct = 15;
                    2:       enq_pct = 70;
                    3:       enq_pct = 30;
                    default: enq_pct = 50;
                endcase
            end
            mode_left--;
            cmd   = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
            qsel  = (focus && $urandom_range(0, 9) < 7) ? qsel_t'(favored)
                                                       : qsel_t'($urandom_range(0, 3));
            value = ($urandom_range(0, 7) == 0) ? corners[$urandom_range(0, 3)]
                                                : data_t'($urandom);
            send_command(cmd, qsel, value, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        // drain: the watchdog ends the run if a result never arrives
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d enqueue and %0d dequeue commands, %0d results checked",
                 enq_sent, deq_sent, results_seen);
        $display("store-full enqueues: %0d, dequeues from an empty queue: %0d",
                 overflows, empties);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
